FILE: hdl/qf_pkg.sv
package qf_pkg;

  localparam int VALUE_W = 16;
  localparam int MAX_ITEMS_DEF = 256;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

FILE: hdl/qf_in_if.sv
interface qf_in_if;
  logic            valid;
  logic            ready;
  qf_pkg::value_t  value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

FILE: hdl/qf_out_if.sv
interface qf_out_if;
  logic            valid;
  logic            ready;
  qf_pkg::value_t  first_quartile;
  qf_pkg::value_t  median;
  qf_pkg::value_t  third_quartile;
  logic            overflow;

  modport source (output valid, output first_quartile, output median,
                  output third_quartile, output overflow, input ready);
  modport sink (input valid, input first_quartile, input median,
                input third_quartile, input overflow, output ready);
endinterface

FILE: hdl/qf_store.sv
module qf_store #(
  parameter int MAX_ITEMS = qf_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
  input  qf_pkg::value_t               wr_data,
  input  logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  output qf_pkg::value_t               rd_data
);

  qf_pkg::value_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/quartile_finder.sv
// Quartile finder: ranks a set of unsigned 16-bit values and reports the
// values at sorted positions n/4, n/2 and 3n/4 (n = values stored).
//
// items channel: one value per beat; last marks the final value of a set.
// results channel: one beat per set, sent after the last value is stored,
// carrying the three ranked values and an overflow flag. Values beyond
// MAX_ITEMS are dropped and flagged.
//
// Values are kept sorted in a single-port-write, registered-read memory by
// insertion: each stored value larger than the new one is read, compared
// and shifted up in S_SHIFT, then the new value is written; into an empty
// store it is written at once, a full store drops it. After the last value,
// S_Q1, S_Q2, S_Q3 and S_EMIT read the three positions and load the result;
// ready is low while a value is being placed or a result is being read out.
// If the receiver stalls, the result register holds; a finished set waits for
// the register to drain, while the next values are taken as long as the
// register is the only thing still waiting.
// Reset clears the count, the overflow flag and the result valid; the memory
// is not cleared and needs no clearing pass.
module quartile_finder #(
  parameter int MAX_ITEMS = qf_pkg::MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qf_in_if.sink     items,
  qf_out_if.source  results
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_Q1    = 3'd3;
  localparam logic [2:0] S_Q2    = 3'd4;
  localparam logic [2:0] S_Q3    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]     state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           ovf, ovf_next;
  logic [AW-1:0]  pos, pos_next;
  qf_pkg::value_t cur, cur_next;
  logic           cur_last, cur_last_next;
  qf_pkg::value_t q1_val, q2_val;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  qf_pkg::value_t wr_data;
  logic [AW-1:0]  rd_addr;
  qf_pkg::value_t rd_data;

  logic           accept;
  logic           full;
  logic           out_free;
  logic [AW-1:0]  q1_addr, q2_addr, q3_addr;
  logic [CW+1:0]  three_n;

  qf_store #(.MAX_ITEMS(MAX_ITEMS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign full        = (count == CW'(MAX_ITEMS));
  assign out_free    = !results.valid || results.ready;

  assign three_n = {1'b0, count, 1'b0} + {2'b00, count};
  assign q1_addr = AW'(count >> 2);
  assign q2_addr = AW'(count >> 1);
  assign q3_addr = AW'(three_n >> 2);

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    pos_next      = pos;
    cur_next      = cur;
    cur_last_next = cur_last;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = cur;
    rd_addr       = pos - AW'(1);
    unique case (state)
      S_IDLE: begin
        rd_addr = AW'(count - CW'(1));
        if (accept) begin
          cur_next      = items.value;
          cur_last_next = items.last;
          if (full) begin
            // drop the value, keep the set going
            ovf_next = 1'b1;
            if (items.last) begin
              state_next = S_Q1;
            end
          end else begin
            count_next = count + CW'(1);
            pos_next   = AW'(count);
            if (count == '0) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = items.value;
              if (items.last) begin
                state_next = S_Q1;
              end
            end else begin
              state_next = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        // rd_data holds the entry just below pos
        if (rd_data > cur) begin
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = rd_data;
          pos_next = pos - AW'(1);
          rd_addr  = pos - AW'(2);
          if (pos == AW'(1)) begin
            state_next = S_PLACE;
          end
        end else begin
          wr_en      = 1'b1;
          wr_addr    = pos;
          wr_data    = cur;
          state_next = cur_last ? S_Q1 : S_IDLE;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = cur;
        state_next = cur_last ? S_Q1 : S_IDLE;
      end
      S_Q1: begin
        rd_addr    = q1_addr;
        state_next = S_Q2;
      end
      S_Q2: begin
        rd_addr    = q2_addr;
        state_next = S_Q3;
      end
      S_Q3: begin
        rd_addr    = q3_addr;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold the third read until the result register drains
        rd_addr = q3_addr;
        if (out_free) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur      <= cur_next;
    cur_last <= cur_last_next;
    if (state == S_Q2) begin
      q1_val <= rd_data;
    end
    if (state == S_Q3) begin
      q2_val <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      results.first_quartile <= q1_val;
      results.median         <= q2_val;
      results.third_quartile <= rd_data;
      results.overflow       <= ovf;
    end
  end

endmodule
